// ----- src/csqrt_pkg.sv -----
package csqrt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // per-stage control carried beside the data
    typedef struct packed {
        logic valid;
        logic re_pos;
        logic im_neg;
    } csqrt_ctl_t;

endpackage

// ----- src/csqrt_pipe.sv -----
// One fully pipelined datapath. Each isqrt and the divide resolve one
// result bit per stage; all side data is carried along in registers.
module csqrt_pipe import csqrt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic signed [DATA_WIDTH-1:0] in_real,
    input  logic signed [DATA_WIDTH-1:0] in_imag,
    output logic                         out_valid,
    output logic        [DATA_WIDTH-2:0] out_real,
    output logic signed [DATA_WIDTH-1:0] out_imag
);
    localparam int DW   = DATA_WIDTH;
    localparam int SQW  = 2 * DW;              // |re|^2+|im|^2 <= 2^(2DW-1)
    localparam int MB   = DW;                  // mag bits
    localparam int RW   = DW + FRAC_BITS;      // radicand width of second root
    localparam int RB   = (RW + 1) / 2;        // second root bits
    localparam int NW   = DW + FRAC_BITS - 1;  // dividend width
    localparam int S1   = 2;                   // abs, squares
    localparam int S2   = S1 + MB;             // first isqrt done
    localparam int S3   = S2 + 1;              // shift
    localparam int S4   = S3 + RB;             // second isqrt done
    localparam int S5   = S4 + NW;             // divide done
    localparam int NST  = S5 + 2;              // output register stage

    // pipeline storage: one slot per stage
    csqrt_ctl_t            ctl_reg   [NST];
    logic [DW-1:0]         ar_reg    [NST];
    logic [DW-1:0]         ai_reg    [NST];
    logic [SQW-1:0]        rem1_reg  [NST];
    logic [MB-1:0]         mag_reg   [NST];
    logic [RW:0]           rem2_reg  [NST];
    logic [RW-1:0]         rad_reg   [NST];
    logic [RB-1:0]         root_reg  [NST];
    logic [NW:0]           rem3_reg  [NST];
    logic [NW-1:0]         quo_reg   [NST];
    logic [DW-2:0]         ore_reg;
    logic [DW-1:0]         oim_reg;

    csqrt_ctl_t            ctl_next  [NST];
    logic [DW-1:0]         ar_next   [NST];
    logic [DW-1:0]         ai_next   [NST];
    logic [SQW-1:0]        rem1_next [NST];
    logic [MB-1:0]         mag_next  [NST];
    logic [RW:0]           rem2_next [NST];
    logic [RW-1:0]         rad_next  [NST];
    logic [RB-1:0]         root_next [NST];
    logic [NW:0]           rem3_next [NST];
    logic [NW-1:0]         quo_next  [NST];
    logic [DW-2:0]         ore_next;
    logic [DW-1:0]         oim_next;

    always_comb begin
        logic [DW-1:0]    ur, ui;
        logic [SQW:0]     trial1;
        logic [RW+1:0]    trial2;
        logic [NW:0]      shd;
        logic [NW-1:0]    qv;
        logic [DW-1:0]    rv;
        logic [RW-1:0]    radv;
        int               k;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                ctl_next[s]  = '0;
                ar_next[s]   = '0;
                ai_next[s]   = '0;
            end else begin
                ctl_next[s]  = ctl_reg[s-1];
                ar_next[s]   = ar_reg[s-1];
                ai_next[s]   = ai_reg[s-1];
            end
            rem1_next[s] = (s == 0) ? '0 : rem1_reg[s-1];
            mag_next[s]  = (s == 0) ? '0 : mag_reg[s-1];
            rem2_next[s] = (s == 0) ? '0 : rem2_reg[s-1];
            rad_next[s]  = (s == 0) ? '0 : rad_reg[s-1];
            root_next[s] = (s == 0) ? '0 : root_reg[s-1];
            rem3_next[s] = (s == 0) ? '0 : rem3_reg[s-1];
            quo_next[s]  = (s == 0) ? '0 : quo_reg[s-1];
        end
        // stage 0: magnitudes and sign flags
        ur = in_real[DW-1] ? DW'(-in_real) : DW'(in_real);
        ui = in_imag[DW-1] ? DW'(-in_imag) : DW'(in_imag);
        ctl_next[0].valid  = in_valid;
        ctl_next[0].re_pos = !in_real[DW-1] && (in_real != '0);
        ctl_next[0].im_neg = in_imag[DW-1];
        ar_next[0] = ur;
        ai_next[0] = ui;
        // stage 1: sum of squares (two DW x DW products)
        rem1_next[1] = SQW'(ar_reg[0]) * SQW'(ar_reg[0])
                     + SQW'(ai_reg[0]) * SQW'(ai_reg[0]);
        mag_next[1] = '0;
        // first isqrt: restoring, one bit per stage, msb first
        for (int s = S1; s < S2; s++) begin
            k = MB - 1 - (s - S1);
            trial1 = {1'b0, rem1_reg[s-1]}
                   - ((({(SQW+1)'(0)} | (SQW+1)'(mag_reg[s-1])) << (k + 1))
                      | ((SQW+1)'(1) << (2 * k)));
            if (!trial1[SQW]) begin
                rem1_next[s] = trial1[SQW-1:0];
                mag_next[s]  = mag_reg[s-1] | (MB'(1) << k);
            end
        end
        // shift stage: radicand (mag+|re|) << (F-1), or zero when mag is zero
        radv = (RW'(mag_reg[S2-1]) + RW'(ar_reg[S2-1])) << (FRAC_BITS - 1);
        rad_next[S2]  = radv;
        rem2_next[S2] = (RW+1)'(radv);
        root_next[S2] = '0;
        if (mag_reg[S2-1] == '0)
            ctl_next[S2].valid = ctl_reg[S2-1].valid;
        mag_next[S2] = mag_reg[S2-1];
        // second isqrt
        for (int s = S3; s < S4; s++) begin
            k = RB - 1 - (s - S3);
            trial2 = {1'b0, rem2_reg[s-1]}
                   - (((RW+2)'(root_reg[s-1]) << (k + 1)) | ((RW+2)'(1) << (2 * k)));
            if (!trial2[RW+1]) begin
                rem2_next[s] = trial2[RW:0];
                root_next[s] = root_reg[s-1] | (RB'(1) << k);
            end
        end
        // divide (|im| << (F-1)) / root, restoring, one quotient bit a stage
        rem3_next[S4] = '0;
        quo_next[S4]  = NW'(ai_reg[S4-1]) << (FRAC_BITS - 1);
        for (int s = S4 + 1; s <= S5; s++) begin
            shd = {rem3_reg[s-1][NW-1:0], quo_reg[s-1][NW-1]};
            qv  = {quo_reg[s-1][NW-2:0], 1'b0};
            if (root_reg[s-1] != '0 && shd >= (NW+1)'(root_reg[s-1])) begin
                shd   = shd - (NW+1)'(root_reg[s-1]);
                qv[0] = 1'b1;
            end
            rem3_next[s] = shd;
            quo_next[s]  = qv;
        end
        // output: place root and quotient, apply signs
        rv = DW'(root_reg[NST-2]);
        qv = (root_reg[NST-2] == '0) ? '0 : quo_reg[NST-2];
        if (mag_reg[NST-2] == '0) begin
            ore_next = '0;
            oim_next = '0;
        end else if (ctl_reg[NST-2].re_pos) begin
            ore_next = rv[DW-2:0];
            oim_next = ctl_reg[NST-2].im_neg ? DW'(-DW'(qv)) : DW'(qv);
        end else begin
            ore_next = qv[DW-2:0];
            oim_next = ctl_reg[NST-2].im_neg ? DW'(-rv) : rv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < NST; s++) begin
                ar_reg[s]   <= ar_next[s];
                ai_reg[s]   <= ai_next[s];
                rem1_reg[s] <= rem1_next[s];
                mag_reg[s]  <= mag_next[s];
                rem2_reg[s] <= rem2_next[s];
                rad_reg[s]  <= rad_next[s];
                root_reg[s] <= root_next[s];
                rem3_reg[s] <= rem3_next[s];
                quo_reg[s]  <= quo_next[s];
                ctl_reg[s].re_pos <= ctl_next[s].re_pos;
                ctl_reg[s].im_neg <= ctl_next[s].im_neg;
            end
            ore_reg <= ore_next;
            oim_reg <= oim_next;
        end
        if (!aresetn) begin
            for (int s = 0; s < NST; s++)
                ctl_reg[s].valid <= 1'b0;
        end else if (adv) begin
            for (int s = 0; s < NST; s++)
                ctl_reg[s].valid <= ctl_next[s].valid;
        end
    end

    assign out_valid = ctl_reg[NST-1].valid;
    assign out_real  = ore_reg;
    assign out_imag  = oim_reg;

endmodule

// ----- src/complex_square_root_top.sv -----
// Channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_in_real, s_in_imag (signed Q16.16)
// result  | m_valid | m_ready | m_out_real (unsigned), m_out_imag (signed)
//
// One beat accepted per cycle while the result side is not stalled. The
// delay from acceptance to the result side is set by the bit-per-stage
// root and divide chains.
// Reset (aresetn, synchronous, low) clears only the valid bits.
// The pipe advances as a whole when its last stage is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
module complex_square_root_top import csqrt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_in_real,
    input  logic signed [DATA_WIDTH-1:0] s_in_imag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [DATA_WIDTH-2:0] m_out_real,
    output logic signed [DATA_WIDTH-1:0] m_out_imag
);
    logic adv;

    // whole-pipe enable: move when the output slot is free or drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    csqrt_pipe #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_real   (s_in_real),
        .in_imag   (s_in_imag),
        .out_valid (m_valid),
        .out_real  (m_out_real),
        .out_imag  (m_out_imag)
    );

`ifndef ASSERT_OFF
    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_real) && $stable(m_out_imag))
        else $error("result changed under stall");
    // no input is taken while a result is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipe stalled");
    // no result right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Scoreboard: predicts the principal square root of each accepted beat and
// compares results in order against the queue of expected roots.
class csqrt_scoreboard;
    logic [30:0] exp_real_q[$];
    logic [31:0] exp_imag_q[$];
    int          n_err;

    function new();
        n_err = 0;
    endfunction

    // floored integer square root, bit by bit
    static function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void note_input(logic [31:0] re, logic [31:0] im);
        logic [63:0] ar, ai, mag, root, quo;
        logic        re_neg, im_neg;
        logic [63:0] o_re, o_im;
        re_neg = re[31];
        im_neg = im[31];
        ar   = re_neg ? {32'd0, (~re) + 32'd1} : {32'd0, re};
        ai   = im_neg ? {32'd0, (~im) + 32'd1} : {32'd0, im};
        mag  = int_sqrt(ar * ar + ai * ai);
        o_re = 0;
        o_im = 0;
        if (mag != 0) begin
            // mag+re for re>0 and mag-re otherwise both equal mag+|re|
            root = int_sqrt((mag + ar) << 15);
            quo  = (root == 0) ? 64'd0 : (ai << 15) / root;
            if (!re_neg && ar != 0) begin
                o_re = root;
                o_im = im_neg ? -quo : quo;
            end else begin
                o_im = im_neg ? -root : root;
                o_re = quo;
            end
        end
        exp_real_q.push_back(o_re[30:0]);
        exp_imag_q.push_back(o_im[31:0]);
    endfunction

    function void check_result(logic [30:0] re, logic [31:0] im);
        if (exp_real_q.size() == 0) begin
            $error("unexpected result beat re=%h im=%h", re, im);
            n_err++;
            return;
        end
        if (re !== exp_real_q[0]) begin
            $error("out_real expected %h actual %h", exp_real_q[0], re);
            n_err++;
        end
        if (im !== exp_imag_q[0]) begin
            $error("out_imag expected %h actual %h", exp_imag_q[0], im);
            n_err++;
        end
        void'(exp_real_q.pop_front());
        void'(exp_imag_q.pop_front());
    endfunction
endclass

module testbench;
    import csqrt_pkg::*;

    localparam int LATENCY    = 2 * 32 + 16 + 24 + 3;
    // idle limit: full pipe latency plus long receiver stalls, many times over
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 880;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_in_real = '0;
    logic signed [31:0] s_in_imag = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic        [30:0] m_out_real;
    logic signed [31:0] m_out_imag;

    csqrt_scoreboard sb;
    bit              calm = 0;  // no idling on either side while set
    int              idle_cycles = 0;

    always #4 aclk = ~aclk;

    complex_square_root_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_real (s_in_real),
        .s_in_imag (s_in_imag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_real(m_out_real),
        .m_out_imag(m_out_imag)
    );

    // Send one beat; optional random gap first, valid held until accepted.
    task automatic send_beat(logic [31:0] re, logic [31:0] im);
        while (!calm && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_real <= re;
        s_in_imag <= im;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(re, im);
    endtask

    // random field: half full range, the rest small or near extreme values
    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0:       return $urandom_range(255) - 128;
            1:       return 32'h8000_0000 + $urandom_range(15);
            2:       return 32'h7fff_ffff - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, beats checked on the edge of acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_out_real, m_out_imag);
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    // watchdog: cycles with no beat accepted on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] dir_re[$];
        logic [31:0] dir_im[$];
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, axis points, signs on all quadrants, extremes
        dir_re = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000, 32'hfffc_0000,
                   32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
                   32'h0003_0000, 32'hfffd_0000, 32'h0003_0000, 32'hfffd_0000,
                   32'h0, 32'h7fff_ffff, 32'h5555_5555};
        dir_im = '{32'h0, 32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 32'h0,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                   32'h0000_0001, 32'h0004_0000, 32'h0004_0000, 32'hfffc_0000,
                   32'hfffc_0000, 32'h0000_0001, 32'h0, 32'haaaa_aaaa};
        foreach (dir_re[k]) send_beat(dir_re[k], dir_im[k]);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 300 && n < 420);  // long stretch at full rate
            send_beat(rand_field(), rand_field());
        end
        s_valid <= 1'b0;
        calm = 0;

        while (sb.exp_real_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        if (sb.n_err == 0 && sb.exp_real_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/csqrt_pkg.sv
src/csqrt_pipe.sv
src/complex_square_root_top.sv
verif/testbench.sv
